@@ design/agsf_pkg.sv @@
// shared types, codes and fixed-point constants of the speed fusion block
package agsf_pkg;

    // configuration port
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int REG_IDX_W  = 2;
    localparam int COEF_W     = 16;

    localparam logic [REG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FUSION  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY = 2'd2;

    localparam logic [COEF_W-1:0] GRAVITY_COEF_RST = 16'd6554;
    localparam logic [COEF_W-1:0] FUSION_COEF_RST  = 16'd64225;
    localparam logic [COEF_W-1:0] DISPLAY_COEF_RST = 16'd655;

    // sample and result fields
    localparam int TIME_W  = 32;
    localparam int ACCEL_W = 16;
    localparam int SPEED_W = 16;

    // internal widths
    localparam int DT_W    = 9;
    localparam int GRAV_W  = 24;
    localparam int VEL_W   = 25;
    localparam int GPSMS_W = 23;
    localparam int DIFF_W  = 27;
    localparam int Z_W     = 30;
    localparam int RND_W   = 28;
    localparam int MUL_W   = 31;
    localparam int PROD_W  = 2 * MUL_W;

    // time step limits in ms
    localparam logic [TIME_W-1:0] DT_MAX     = 32'd500;
    localparam logic [DT_W-1:0]   DT_DEFAULT = 9'd10;

    // reciprocal multipliers: floor(x * RECIP >> SH) == floor(x / divisor) over our ranges
    localparam logic [26:0] RECIP9   = 27'd119304648;
    localparam logic [28:0] RECIP125 = 29'd274877907;
    localparam logic [21:0] RECIP5   = 22'd3355444;

    // display speed below 0.1 m/s in Q8.16 shows as zero
    localparam logic signed [VEL_W-1:0] SLOW_LIMIT = 25'sd6554;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE      = 5'd0,
        OP_CAPTURE   = 5'd1,
        OP_MUL_GPS   = 5'd2,
        OP_POST_GPS  = 5'd3,
        OP_MUL_GRAV  = 5'd4,
        OP_POST_GRAV = 5'd5,
        OP_PREP_LIN  = 5'd6,
        OP_MUL_LIN   = 5'd7,
        OP_POST_LIN  = 5'd8,
        OP_MUL_DV    = 5'd9,
        OP_POST_DV   = 5'd10,
        OP_PREP_FUS  = 5'd11,
        OP_MUL_FUS   = 5'd12,
        OP_POST_FUS  = 5'd13,
        OP_PREP_DISP = 5'd14,
        OP_MUL_DISP  = 5'd15,
        OP_POST_DISP = 5'd16,
        OP_PREP_INST = 5'd17,
        OP_MUL_OUT   = 5'd18,
        OP_POST_INST = 5'd19,
        OP_PREP_SM   = 5'd20,
        OP_POST_SM   = 5'd21
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

endpackage

@@ design/agsf_regs.sv @@
// apb-style register file holding the three filter weights
module agsf_regs import agsf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [COEF_W-1:0] o_gravity_coef,
    output logic [COEF_W-1:0] o_fusion_coef,
    output logic [COEF_W-1:0] o_display_coef
);

    logic [COEF_W-1:0]    r_gravity_coef;
    logic [COEF_W-1:0]    r_fusion_coef;
    logic [COEF_W-1:0]    r_display_coef;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity_coef <= GRAVITY_COEF_RST;
            r_fusion_coef  <= FUSION_COEF_RST;
            r_display_coef <= DISPLAY_COEF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GRAVITY: r_gravity_coef <= pwdata[COEF_W-1:0];
                REG_FUSION:  r_fusion_coef  <= pwdata[COEF_W-1:0];
                REG_DISPLAY: r_display_coef <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_GRAVITY: prdata = DATA_W'(r_gravity_coef);
            REG_FUSION:  prdata = DATA_W'(r_fusion_coef);
            REG_DISPLAY: prdata = DATA_W'(r_display_coef);
            default:     prdata = '0;
        endcase
    end

    assign o_gravity_coef = r_gravity_coef;
    assign o_fusion_coef  = r_fusion_coef;
    assign o_display_coef = r_display_coef;

endmodule

@@ design/agsf_ctrl.sv @@
// sequencer that steps the shared-multiplier datapath through one sample
module agsf_ctrl import agsf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  logic    i_seeded,
    output t_dp_cmd o_cmd
);

    typedef enum logic [22:0] {
        S_IDLE      = 23'h000001,
        S_GPS_MUL   = 23'h000002,
        S_GPS_POST  = 23'h000004,
        S_GRAV_MUL  = 23'h000008,
        S_GRAV_POST = 23'h000010,
        S_LIN_PREP  = 23'h000020,
        S_LIN_MUL   = 23'h000040,
        S_LIN_POST  = 23'h000080,
        S_DV_MUL    = 23'h000100,
        S_DV_POST   = 23'h000200,
        S_FUS_PREP  = 23'h000400,
        S_FUS_MUL   = 23'h000800,
        S_FUS_POST  = 23'h001000,
        S_DSP_PREP  = 23'h002000,
        S_DSP_MUL   = 23'h004000,
        S_DSP_POST  = 23'h008000,
        S_INST_PREP = 23'h010000,
        S_INST_MUL  = 23'h020000,
        S_INST_POST = 23'h040000,
        S_SM_PREP   = 23'h080000,
        S_SM_MUL    = 23'h100000,
        S_SM_POST   = 23'h200000,
        S_DONE      = 23'h400000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        o_cmd.op       = OP_NONE;
        o_cmd.load_out = 1'b0;
        o_in_ready   = 1'b0;

        // result transfer frees the output register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_GPS_MUL;
                end
            end
            S_GPS_MUL: begin
                o_cmd.op = OP_MUL_GPS;
                n_state  = S_GPS_POST;
            end
            S_GPS_POST: begin
                // first sample seeds the filters and skips straight to the outputs
                o_cmd.op = OP_POST_GPS;
                n_state  = i_seeded ? S_GRAV_MUL : S_INST_PREP;
            end
            S_GRAV_MUL: begin
                o_cmd.op = OP_MUL_GRAV;
                n_state  = S_GRAV_POST;
            end
            S_GRAV_POST: begin
                o_cmd.op = OP_POST_GRAV;
                n_state  = S_LIN_PREP;
            end
            S_LIN_PREP: begin
                o_cmd.op = OP_PREP_LIN;
                n_state  = S_LIN_MUL;
            end
            S_LIN_MUL: begin
                o_cmd.op = OP_MUL_LIN;
                n_state  = S_LIN_POST;
            end
            S_LIN_POST: begin
                o_cmd.op = OP_POST_LIN;
                n_state  = S_DV_MUL;
            end
            S_DV_MUL: begin
                o_cmd.op = OP_MUL_DV;
                n_state  = S_DV_POST;
            end
            S_DV_POST: begin
                o_cmd.op = OP_POST_DV;
                n_state  = S_FUS_PREP;
            end
            S_FUS_PREP: begin
                o_cmd.op = OP_PREP_FUS;
                n_state  = S_FUS_MUL;
            end
            S_FUS_MUL: begin
                o_cmd.op = OP_MUL_FUS;
                n_state  = S_FUS_POST;
            end
            S_FUS_POST: begin
                o_cmd.op = OP_POST_FUS;
                n_state  = S_DSP_PREP;
            end
            S_DSP_PREP: begin
                o_cmd.op = OP_PREP_DISP;
                n_state  = S_DSP_MUL;
            end
            S_DSP_MUL: begin
                o_cmd.op = OP_MUL_DISP;
                n_state  = S_DSP_POST;
            end
            S_DSP_POST: begin
                o_cmd.op = OP_POST_DISP;
                n_state  = S_INST_PREP;
            end
            S_INST_PREP: begin
                o_cmd.op = OP_PREP_INST;
                n_state  = S_INST_MUL;
            end
            S_INST_MUL: begin
                o_cmd.op = OP_MUL_OUT;
                n_state  = S_INST_POST;
            end
            S_INST_POST: begin
                o_cmd.op = OP_POST_INST;
                n_state  = S_SM_PREP;
            end
            S_SM_PREP: begin
                o_cmd.op = OP_PREP_SM;
                n_state  = S_SM_MUL;
            end
            S_SM_MUL: begin
                o_cmd.op = OP_MUL_OUT;
                n_state  = S_SM_POST;
            end
            S_SM_POST: begin
                o_cmd.op = OP_POST_SM;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // wait here only while an older result is still untaken
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/agsf_dp.sv @@
// fixed-point datapath: filter state, shared multiplier, rounding and saturation
module agsf_dp import agsf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [TIME_W-1:0]         i_time_ms,
    input  logic signed [ACCEL_W-1:0] i_accel_fwd,
    input  logic [SPEED_W-1:0]        i_gps_speed,
    input  logic [COEF_W-1:0]         i_gravity_coef,
    input  logic [COEF_W-1:0]         i_fusion_coef,
    input  logic [COEF_W-1:0]         i_display_coef,
    output logic                      o_seeded,
    output logic [SPEED_W-1:0]        o_smoothed_speed,
    output logic signed [SPEED_W-1:0] o_instant_speed
);

    localparam logic signed [RND_W-1:0] VEL_MAX = 28'sd16777215;
    localparam logic signed [RND_W-1:0] VEL_MIN = -28'sd16777216;

    // divide by 65536 with ties away from zero after adding b
    function automatic logic signed [RND_W-1:0] round_q16(
        input logic signed [PROD_W-1:0] p,
        input logic signed [RND_W-1:0]  b
    );
        logic signed [RND_W-1:0] q;
        logic [15:0]             frac;
        logic                    inc;
        q    = $signed(p[RND_W+15:16]) + b;
        frac = p[15:0];
        inc  = (frac > 16'h8000) || ((frac == 16'h8000) && !q[RND_W-1]);
        return q + RND_W'(inc);
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [RND_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v > VEL_MAX) begin
            r = VEL_MAX[VEL_W-1:0];
        end else if (v < VEL_MIN) begin
            r = VEL_MIN[VEL_W-1:0];
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

    // sign and (|v|*9 + 320) >> 7, the first half of a rounded *9/640
    function automatic logic [21:0] prep_scale(input logic signed [VEL_W-1:0] v);
        logic signed [28:0] t9;
        logic [27:0]        ysum;
        t9 = (29'(v) <<< 3) + 29'(v);
        if (v[VEL_W-1]) begin
            ysum = 28'(29'sd320 - t9);
        end else begin
            ysum = 28'(t9 + 29'sd320);
        end
        return {v[VEL_W-1], ysum[27:7]};
    endfunction

    logic                        r_seeded;
    logic [TIME_W-1:0]           r_last_time;
    logic signed [GRAV_W-1:0]    r_grav;
    logic signed [VEL_W-1:0]     r_fused;
    logic signed [VEL_W-1:0]     r_disp;
    logic signed [ACCEL_W-1:0]   r_accel;
    logic [DT_W-1:0]             r_dt;
    logic [GPSMS_W-1:0]          r_gps_ms;
    logic signed [DIFF_W-1:0]    r_diff;
    logic [Z_W-1:0]              r_z;
    logic                        r_neg;
    logic                        r_slow;
    logic signed [VEL_W-1:0]     r_dv;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SPEED_W-1:0]   r_inst;
    logic [SPEED_W-1:0]          r_sm;
    logic signed [SPEED_W-1:0]   r_out_inst;
    logic [SPEED_W-1:0]          r_out_sm;

    logic signed [MUL_W-1:0]     mul_a;
    logic signed [MUL_W-1:0]     mul_b;
    logic                        mul_en;
    logic signed [DIFF_W-1:0]    a16;
    logic [TIME_W-1:0]           dt_raw;
    logic [25:0]                 gps_y;
    logic [GPSMS_W-1:0]          gps_ms;
    logic signed [34:0]          lin_dt;
    logic [34:0]                 dv_sum;
    logic [23:0]                 dv_q;
    logic [18:0]                 out_q;
    logic [21:0]                 scale_fused;
    logic [21:0]                 scale_disp;
    logic [19:0]                 inst_neg;

    // operand selection for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        case (i_cmd.op)
            OP_MUL_GPS: begin
                mul_a = {1'b0, r_z};
                mul_b = MUL_W'(RECIP9);
            end
            OP_MUL_GRAV: begin
                mul_a = {{(MUL_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = MUL_W'(i_gravity_coef);
            end
            OP_MUL_LIN: begin
                mul_a = {{(MUL_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = MUL_W'(r_dt);
            end
            OP_MUL_DV: begin
                mul_a = {1'b0, r_z};
                mul_b = MUL_W'(RECIP125);
            end
            OP_MUL_FUS: begin
                mul_a = {{(MUL_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = MUL_W'(i_fusion_coef);
            end
            OP_MUL_DISP: begin
                mul_a = {{(MUL_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
                mul_b = MUL_W'(i_display_coef);
            end
            OP_MUL_OUT: begin
                mul_a = {1'b0, r_z};
                mul_b = MUL_W'(RECIP5);
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign a16         = {{(DIFF_W-GRAV_W){r_accel[ACCEL_W-1]}}, r_accel, 8'b0};
    assign dt_raw      = i_time_ms - r_last_time;
    assign gps_y       = {1'b0, i_gps_speed, 9'b0} + {3'b0, i_gps_speed, 7'b0} + 26'd4;
    assign gps_ms      = r_prod[52:30];
    assign lin_dt      = r_prod[34:0];
    // |lin*dt| + 500, the negative side as 500 - x
    assign dv_sum      = lin_dt[34] ? (~lin_dt + 35'd501) : (lin_dt + 35'd500);
    assign dv_q        = r_prod[58:35];
    assign out_q       = r_prod[42:24];
    assign scale_fused = prep_scale(r_fused);
    assign scale_disp  = prep_scale(r_disp);
    assign inst_neg    = 20'd0 - {1'b0, out_q};

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (i_cmd.op == OP_POST_GPS) begin
            r_seeded <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_accel     <= i_accel_fwd;
                r_last_time <= i_time_ms;
                r_z         <= Z_W'(gps_y);
                r_diff      <= {{(DIFF_W-GRAV_W){i_accel_fwd[ACCEL_W-1]}}, i_accel_fwd, 8'b0}
                               - DIFF_W'(r_grav);
                if (dt_raw == '0 || dt_raw > DT_MAX) begin
                    r_dt <= DT_DEFAULT;
                end else begin
                    r_dt <= dt_raw[DT_W-1:0];
                end
            end
            OP_POST_GPS: begin
                r_gps_ms <= gps_ms;
                if (!r_seeded) begin
                    r_grav  <= {r_accel, 8'b0};
                    r_fused <= VEL_W'(gps_ms);
                    r_disp  <= VEL_W'(gps_ms);
                end
            end
            OP_POST_GRAV: begin
                r_grav <= GRAV_W'(round_q16(r_prod, RND_W'(r_grav)));
            end
            OP_PREP_LIN: begin
                r_diff <= a16 - DIFF_W'(r_grav);
            end
            OP_POST_LIN: begin
                r_neg <= lin_dt[34];
                r_z   <= dv_sum[32:3];
            end
            OP_POST_DV: begin
                if (r_neg) begin
                    r_dv <= -$signed({1'b0, dv_q});
                end else begin
                    r_dv <= $signed({1'b0, dv_q});
                end
            end
            OP_PREP_FUS: begin
                r_diff <= DIFF_W'(r_fused) + DIFF_W'(r_dv) - DIFF_W'(r_gps_ms);
            end
            OP_POST_FUS: begin
                r_fused <= sat_vel(round_q16(r_prod, RND_W'(r_gps_ms)));
            end
            OP_PREP_DISP: begin
                r_diff <= DIFF_W'(r_fused) - DIFF_W'(r_disp);
            end
            OP_POST_DISP: begin
                r_disp <= sat_vel(round_q16(r_prod, RND_W'(r_disp)));
            end
            OP_PREP_INST: begin
                r_neg <= scale_fused[21];
                r_z   <= Z_W'(scale_fused[20:0]);
            end
            OP_POST_INST: begin
                if (r_neg) begin
                    r_inst <= (out_q > 19'd32768) ? 16'sh8000 : $signed(inst_neg[15:0]);
                end else begin
                    r_inst <= (out_q > 19'd32767) ? 16'sh7FFF : $signed(out_q[15:0]);
                end
            end
            OP_PREP_SM: begin
                r_neg  <= scale_disp[21];
                r_z    <= Z_W'(scale_disp[20:0]);
                r_slow <= r_disp < SLOW_LIMIT;
            end
            OP_POST_SM: begin
                if (r_slow) begin
                    r_sm <= '0;
                end else if (out_q > 19'd65535) begin
                    r_sm <= 16'hFFFF;
                end else begin
                    r_sm <= out_q[15:0];
                end
            end
            default: ;
        endcase
    end

    // output register, separate so the next sample can run while a result waits
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_inst <= r_inst;
            r_out_sm   <= r_sm;
        end
    end

    assign o_seeded         = r_seeded;
    assign o_instant_speed  = r_out_inst;
    assign o_smoothed_speed = r_out_sm;

endmodule

@@ design/accel_gps_speed_fusion_core.sv @@
// top level of the accelerometer and gps speed fusion block
// Fuses forward acceleration with GPS speed through a complementary filter and
// gives one result (display speed and instant speed, Q8.8 km/h) per sample. A
// sample is taken only while the block is idle; it is then worked through one
// shared 31x31 multiplier, each multiply followed by a post-processing step of
// rounding, saturation or scaling; the very first sample after reset only seeds
// the filters and skips their update steps. The finished result sits in an
// output register, so the next sample is accepted while a result still waits
// for its transfer; a sample that finishes while the older result is still
// untaken holds in its last step until that transfer. The three filter weights
// are written over the APB-style port at byte addresses 0, 4, 8.
module accel_gps_speed_fusion_core import agsf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [TIME_W-1:0]         i_time_ms,
    input  logic signed [ACCEL_W-1:0] i_accel_fwd,
    input  logic [SPEED_W-1:0]        i_gps_speed,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [SPEED_W-1:0]        o_smoothed_speed,
    output logic signed [SPEED_W-1:0] o_instant_speed,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    logic [COEF_W-1:0] gravity_coef;
    logic [COEF_W-1:0] fusion_coef;
    logic [COEF_W-1:0] display_coef;
    logic              seeded;
    t_dp_cmd           dp_cmd;

    agsf_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_gravity_coef (gravity_coef),
        .o_fusion_coef  (fusion_coef),
        .o_display_coef (display_coef)
    );

    agsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_seeded    (seeded),
        .o_cmd       (dp_cmd)
    );

    agsf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_time_ms        (i_time_ms),
        .i_accel_fwd      (i_accel_fwd),
        .i_gps_speed      (i_gps_speed),
        .i_gravity_coef   (gravity_coef),
        .i_fusion_coef    (fusion_coef),
        .i_display_coef   (display_coef),
        .o_seeded         (seeded),
        .o_smoothed_speed (o_smoothed_speed),
        .o_instant_speed  (o_instant_speed)
    );

`ifndef SYNTHESIS
    // a sample transfer starts work, so the input side closes the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while a sample is in work");

    // the output register is reloaded only when its result is gone or leaving
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before its transfer");

    a_valid_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

    // once seeded the filters stay seeded until reset
    a_seeded_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seeded |=> seeded)
        else $error("seeded flag dropped");
`endif

endmodule

@@ bench/tb.sv @@
// testbench for accel_gps_speed_fusion_core: queued driver, checking monitor, fused speed predictor
module tb import agsf_pkg::*; ();

    localparam longint ONE_Q16          = 65536;
    localparam longint VEL_HI           = 16777215;
    localparam longint VEL_LO           = -16777216;
    localparam int     STEP_MAX_MS      = 500;
    localparam int     STEP_FALLBACK_MS = 10;
    localparam int     IDLE_LIMIT       = 2000;
    localparam int     RANDOM_PHASES    = 8;
    localparam int     PHASE_SAMPLES    = 165;

    // no register lives at this index, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0]         time_ms;
        logic signed [ACCEL_W-1:0] accel;
        logic [SPEED_W-1:0]        gps;
    } t_sample;

    typedef struct packed {
        logic [SPEED_W-1:0]        smoothed;
        logic signed [SPEED_W-1:0] instant;
    } t_speed_pair;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic [TIME_W-1:0]         time_ms     = '0;
    logic signed [ACCEL_W-1:0] accel_fwd   = '0;
    logic [SPEED_W-1:0]        gps_speed   = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b1;
    logic [SPEED_W-1:0]        smoothed_speed;
    logic signed [SPEED_W-1:0] instant_speed;
    logic                      psel        = 1'b0;
    logic                      penable     = 1'b0;
    logic                      pwrite      = 1'b0;
    logic [ADDR_W-1:0]         paddr       = '0;
    logic [DATA_W-1:0]         pwdata      = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    accel_gps_speed_fusion_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_time_ms        (time_ms),
        .i_accel_fwd      (accel_fwd),
        .i_gps_speed      (gps_speed),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_smoothed_speed (smoothed_speed),
        .o_instant_speed  (instant_speed),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the weights and the filter state
    logic [COEF_W-1:0] grav_coef = GRAVITY_COEF_RST;
    logic [COEF_W-1:0] fus_coef  = FUSION_COEF_RST;
    logic [COEF_W-1:0] disp_coef = DISPLAY_COEF_RST;
    bit                seeded_q  = 1'b0;
    logic [TIME_W-1:0] last_ms   = '0;
    longint            grav_q16  = 0;
    longint            fused_v   = 0;
    longint            disp_v    = 0;

    t_sample     pending_samples[$];
    t_speed_pair expected_speeds[$];
    t_sample     cur;
    int          queued_count = 0;
    int          taken_count  = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          quiet        = 0;
    bit          calm         = 1'b0;
    bit          failed       = 1'b0;
    logic [TIME_W-1:0]  t_now    = '0;
    logic [SPEED_W-1:0] gps_prev = '0;

    // round to nearest, ties away from zero, d > 0
    function automatic longint div_round(longint x, longint d);
        if (x >= 0) return (x + d / 2) / d;
        return -((-x + d / 2) / d);
    endfunction

    function automatic longint clamp_vel(longint v);
        if (v > VEL_HI) return VEL_HI;
        if (v < VEL_LO) return VEL_LO;
        return v;
    endfunction

    function automatic longint mix_q16(logic [COEF_W-1:0] c, longint a, longint b);
        longint w;
        w = c;
        return clamp_vel(div_round(w * a + (ONE_Q16 - w) * b, ONE_Q16));
    endfunction

    function automatic t_speed_pair fuse_sample(t_sample s);
        longint            a16;
        longint            gps_ms;
        longint            lin;
        longint            dv;
        longint            sm;
        longint            inst;
        longint            gw;
        logic [TIME_W-1:0] dt;
        t_speed_pair       r;
        a16    = longint'($signed(s.accel)) * 256;
        gps_ms = div_round(longint'(s.gps) * 640, 9);
        if (!seeded_q) begin
            grav_q16 = a16;
            fused_v  = clamp_vel(gps_ms);
            disp_v   = fused_v;
            last_ms  = s.time_ms;
            seeded_q = 1'b1;
        end else begin
            dt      = s.time_ms - last_ms;
            last_ms = s.time_ms;
            if (dt == 0 || dt > STEP_MAX_MS) dt = STEP_FALLBACK_MS;
            gw       = grav_coef;
            grav_q16 = div_round(gw * a16 + (ONE_Q16 - gw) * grav_q16, ONE_Q16);
            lin      = a16 - grav_q16;
            dv       = div_round(lin * longint'(dt), 1000);
            fused_v  = mix_q16(fus_coef, fused_v + dv, gps_ms);
            disp_v   = mix_q16(disp_coef, fused_v, disp_v);
        end
        // below 0.1 m/s the display reads zero
        if (disp_v * 10 < ONE_Q16) begin
            sm = 0;
        end else begin
            sm = div_round(disp_v * 9, 640);
            if (sm > 65535) sm = 65535;
        end
        inst = div_round(fused_v * 9, 640);
        if (inst > 32767) inst = 32767;
        if (inst < -32768) inst = -32768;
        r.smoothed = sm[SPEED_W-1:0];
        r.instant  = inst[SPEED_W-1:0];
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(logic [COEF_W-1:0] dflt);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return dflt;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // mostly sane time steps, some repeated, late or scrambled timestamps
    function automatic t_sample random_sample();
        t_sample s;
        int      pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) t_now = t_now + $urandom_range(1, STEP_MAX_MS);
        else if (pick == 8) t_now = t_now + $urandom_range(STEP_MAX_MS + 1, 200000);
        else if (pick == 9) t_now = $urandom;
        s.time_ms = t_now;
        pick = $urandom_range(0, 9);
        if (pick < 5) s.accel = ACCEL_W'($urandom_range(0, 1023)) - 16'd512;
        else if (pick < 8) s.accel = ACCEL_W'($urandom);
        else if (pick == 8) s.accel = 16'sh7fff;
        else s.accel = 16'sh8000;
        pick = $urandom_range(0, 9);
        if (pick < 4) s.gps = SPEED_W'($urandom_range(0, 3000));
        else if (pick < 7) s.gps = SPEED_W'($urandom);
        else s.gps = gps_prev + SPEED_W'($urandom_range(0, 200)) - 16'd100;
        gps_prev = s.gps;
        return s;
    endfunction

    task automatic push_sample(logic [TIME_W-1:0] t, logic signed [ACCEL_W-1:0] a,
                               logic [SPEED_W-1:0] g);
        t_sample s;
        s.time_ms = t;
        s.accel   = a;
        s.gps     = g;
        pending_samples.push_back(s);
        queued_count++;
        t_now = t;
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low half of the data word is kept
        case (idx)
            REG_GRAVITY: grav_coef = value[COEF_W-1:0];
            REG_FUSION:  fus_coef  = value[COEF_W-1:0];
            REG_DISPLAY: disp_coef = value[COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_coefs(logic [COEF_W-1:0] g, logic [COEF_W-1:0] f,
                             logic [COEF_W-1:0] d);
        write_reg(REG_GRAVITY, {16'($urandom), g});
        write_reg(REG_FUSION,  {16'($urandom), f});
        write_reg(REG_DISPLAY, {16'($urandom), d});
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (taken_count != queued_count || expected_speeds.size() != 0);
    endtask

    // sample driver
    always @(posedge i_clk) begin : drive
        bit took;
        bit nxt_valid;
        took      = in_valid && in_ready;
        nxt_valid = in_valid && !took;
        if (took) begin
            expected_speeds.push_back(fuse_sample(cur));
            taken_count++;
        end
        if (i_rst_n && !nxt_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_samples.size() > 0) begin
                cur = pending_samples.pop_front();
                time_ms   <= cur.time_ms;
                accel_fwd <= cur.accel;
                gps_speed <= cur.gps;
                nxt_valid = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
            end
        end
        in_valid <= nxt_valid;
    end

    // result monitor
    always @(posedge i_clk) begin : watch
        t_speed_pair want;
        bit          rdy;
        if (out_valid && out_ready) begin
            if (expected_speeds.size() == 0) begin
                failed = 1'b1;
                $display("%0t: unexpected result smoothed_speed=%0d instant_speed=%0d",
                         $time, smoothed_speed, instant_speed);
            end else begin
                want = expected_speeds.pop_front();
                if (smoothed_speed !== want.smoothed) begin
                    failed = 1'b1;
                    $display("%0t: smoothed_speed expected %0d got %0d",
                             $time, want.smoothed, smoothed_speed);
                end
                if (instant_speed !== want.instant) begin
                    failed = 1'b1;
                    $display("%0t: instant_speed expected %0d got %0d",
                             $time, want.instant, instant_speed);
                end
            end
        end
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 5);
            rdy = 1'b0;
        end
        out_ready <= rdy;
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
        else quiet++;
        if (quiet >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("accel_gps_speed_fusion_core verification failed");
            $finish;
        end
    end

    initial begin
        logic [TIME_W-1:0] t;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // seeding, repeated stamp, wrap, late and backward steps, field extremes
        t = 32'hFFFF_FF00;
        push_sample(t, 16'sd0, 16'd1000);
        push_sample(t, 16'sh7fff, 16'hffff);
        push_sample(t + 500, 16'sh7fff, 16'hffff);
        push_sample(t + 1001, 16'sh8000, 16'd0);
        push_sample(t + 1002, 16'sh8000, 16'd0);
        push_sample(t + 997, 16'sd0, 16'd0);
        wait_idle();

        // pull gravity back near zero
        write_reg(REG_GRAVITY, {16'hA5A5, 16'hffff});
        push_sample(t_now + 10, 16'sd0, 16'd0);
        wait_idle();

        // pure integration: drive velocity into both saturation limits
        set_coefs('0, '1, '1);
        write_reg(REG_UNUSED, $urandom);
        repeat (5) push_sample(t_now + 500, 16'sh7fff, 16'hffff);
        repeat (9) push_sample(t_now + 500, 16'sh8000, 16'd0);
        wait_idle();

        // fused follows gps alone, display follows fused: straddle the slow limit
        write_reg(REG_FUSION, {16'h5A5A, 16'h0000});
        push_sample(t_now + 10, 16'sd0, 16'd92);
        push_sample(t_now + 10, 16'sd0, 16'd93);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == 3) || (p == RANDOM_PHASES - 1);
            set_coefs(pick_coef(GRAVITY_COEF_RST), pick_coef(FUSION_COEF_RST),
                      pick_coef(DISPLAY_COEF_RST));
            if (p == 2) write_reg(REG_UNUSED, $urandom);
            repeat (PHASE_SAMPLES) begin
                pending_samples.push_back(random_sample());
                queued_count++;
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (expected_speeds.size() != 0) begin
            failed = 1'b1;
            $display("%0t: %0d results never arrived", $time, expected_speeds.size());
        end
        if (!failed)
            $display("accel_gps_speed_fusion_core verification clean");
        else
            $display("accel_gps_speed_fusion_core verification failed");
        $finish;
    end

endmodule

@@ files.f @@
design/agsf_pkg.sv
design/agsf_regs.sv
design/agsf_ctrl.sv
design/agsf_dp.sv
design/accel_gps_speed_fusion_core.sv
bench/tb.sv
